>>> rtl/ohci_pkg.sv
// shared constants and types for the ohci register window
package ohci_pkg;
  localparam int unsigned TxContextsDefault = 4;
  localparam int unsigned RxContextsDefault = 4;
  localparam int unsigned AddrW = 11;
  localparam int unsigned DataW = 32;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [AddrW-1:0] AddrMask = 11'h7FC;
  localparam logic [DataW-1:0] SoftResetBit = 32'h0001_0000;

  typedef struct packed {
    logic             op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } access_t;

  function automatic int plain_index(logic [AddrW-1:0] a);
    unique case (a)
      11'h008: return 0;
      11'h00C: return 1;
      11'h010: return 2;
      11'h014: return 3;
      11'h018: return 4;
      11'h020: return 5;
      11'h034: return 6;
      11'h038: return 7;
      11'h03C: return 8;
      11'h064: return 9;
      11'h0DC: return 10;
      11'h0EC: return 11;
      11'h120: return 12;
      default: return -1;
    endcase
  endfunction

  function automatic int pair_index(logic [AddrW-1:0] a);
    unique case ({a[10:3], 3'b000})
      11'h070: return 0;
      11'h078: return 1;
      11'h090: return 2;
      11'h098: return 3;
      11'h0A0: return 4;
      11'h0A8: return 5;
      11'h0E0: return 6;
      11'h100: return 7;
      11'h108: return 8;
      11'h110: return 9;
      11'h118: return 10;
      default: return -1;
    endcase
  endfunction
endpackage

>>> rtl/ohci_regs.sv
// register storage, decode, update and read mux for one access
module ohci_regs #(
  parameter int unsigned TX_CONTEXTS = ohci_pkg::TxContextsDefault,
  parameter int unsigned RX_CONTEXTS = ohci_pkg::RxContextsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  ohci_pkg::access_t         acc_i,
  output logic [ohci_pkg::DataW-1:0] rdata_o,
  output logic                      irq_o
);
  localparam int unsigned DW = ohci_pkg::DataW;
  localparam int unsigned TxIdxW = $clog2(4*TX_CONTEXTS);
  localparam int unsigned RxIdxW = $clog2(4*RX_CONTEXTS);

  logic [DW-1:0] plain_q [13];
  logic [DW-1:0] pair_q [11];
  logic [DW-1:0] async_q [8];
  logic [DW-1:0] tx_q [4*TX_CONTEXTS];
  logic [DW-1:0] rx_q [4*RX_CONTEXTS];
  logic [DW-1:0] hc_q, ev_q, mk_q;

  logic [ohci_pkg::AddrW-1:0] a;
  logic [DW-1:0] d;
  logic wr;
  int pidx, qidx;
  logic pv, qv, av, tv, rv;
  logic [3:0] pi, qi;
  logic [2:0] ai;
  logic [TxIdxW-1:0] ti;
  logic [RxIdxW-1:0] ri;

  assign a  = acc_i.addr;
  assign d  = acc_i.data;
  assign wr = en_i && (acc_i.op == ohci_pkg::OpWrite);

  always_comb begin
    pidx = ohci_pkg::plain_index(a);
    qidx = ohci_pkg::pair_index(a);
    pv = (pidx >= 0);
    qv = (qidx >= 0);
    pi = 4'(pidx);
    qi = 4'(qidx);
    av = 1'b0;
    ai = '0;
    tv = 1'b0;
    ti = '0;
    rv = 1'b0;
    ri = '0;
    if (a >= 11'h180 && a < 11'h200) begin
      if (a[4:0] == 5'h00 || a[4:0] == 5'h04) begin
        av = 1'b1;
        ai = {a[6:5], 1'b0};
      end else if (a[4:0] == 5'h0C) begin
        av = 1'b1;
        ai = {a[6:5], 1'b1};
      end
    end
    if (32'(a) >= 32'h200 && 32'(a) < 32'h200 + 32'(TX_CONTEXTS) * 32'h10) begin
      tv = 1'b1;
      ti = TxIdxW'((32'(a) - 32'h200) >> 2);
    end
    if (32'(a) >= 32'h400 && 32'(a) < 32'h400 + 32'(RX_CONTEXTS) * 32'h20) begin
      if (a[4:0] <= 5'h0C) begin
        rv = 1'b1;
        ri = RxIdxW'((((32'(a) - 32'h400) >> 5) << 2) | 32'(a[3:2]));
      end else if (a[4:0] == 5'h10) begin
        rv = 1'b1;
        ri = RxIdxW'((((32'(a) - 32'h400) >> 5) << 2) | 32'd3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= '0;
      ev_q <= '0;
      mk_q <= '0;
      for (int i = 0; i < 13; i++) plain_q[i] <= '0;
      for (int i = 0; i < 11; i++) pair_q[i] <= '0;
      for (int i = 0; i < 8; i++) async_q[i] <= '0;
      for (int i = 0; i < 4*TX_CONTEXTS; i++) tx_q[i] <= '0;
      for (int i = 0; i < 4*RX_CONTEXTS; i++) rx_q[i] <= '0;
    end else if (wr) begin
      priority if (a == 11'h050) hc_q <= hc_q | d;
      else if (a == 11'h054) hc_q <= hc_q & ~d & ~ohci_pkg::SoftResetBit;
      else if (a == 11'h080) ev_q <= ev_q | d;
      else if (a == 11'h084) ev_q <= ev_q & ~d;
      else if (a == 11'h088) mk_q <= mk_q | d;
      else if (a == 11'h08C) mk_q <= mk_q & ~d;
      else if (pv) plain_q[pi] <= d;
      else if (qv) begin
        if (a[2]) pair_q[qi] <= pair_q[qi] & ~d;
        else pair_q[qi] <= pair_q[qi] | d;
      end
      else if (av) async_q[ai] <= d;
      else if (tv) tx_q[ti] <= d;
      else if (rv) rx_q[ri] <= d;
    end
  end

  always_comb begin
    rdata_o = '0;
    unique case (a)
      11'h000: rdata_o = 32'h0001_0001;
      11'h01C: rdata_o = 32'h3133_3934;
      11'h024: rdata_o = 32'h0011_24FF;
      11'h028: rdata_o = 32'hFEE4_C4E0;
      11'h040: rdata_o = 32'h0008_0024;
      11'h068: rdata_o = 32'h8000_0000;
      11'h0B0: rdata_o = 32'h0000_0F00;
      11'h0B4: rdata_o = 32'hFFFF_FFFE;
      11'h0B8: rdata_o = 32'hFFFF_FFFF;
      11'h0EC: rdata_o = 32'h8000_0000;
      11'h0E8: rdata_o = hc_q[17] ? 32'hC000_0000 : '0;
      11'h050, 11'h054: rdata_o = hc_q;
      11'h080, 11'h084: rdata_o = ev_q;
      11'h088, 11'h08C: rdata_o = mk_q;
      default: begin
        priority if (pv) rdata_o = plain_q[pi];
        else if (qv) rdata_o = pair_q[qi];
        else if (av) rdata_o = async_q[ai];
        else if (tv) rdata_o = tx_q[ti];
        else if (rv) rdata_o = rx_q[ri];
        else rdata_o = '0;
      end
    endcase
    if (acc_i.op == ohci_pkg::OpWrite) rdata_o = '0;
  end

  assign irq_o = mk_q[31] && |(ev_q & mk_q);
endmodule

>>> rtl/ohci_1394_register_file_top.sv
// ohci 1394 register window with stream handshake
// result passes through the capture register (prd_q) and then the output register before it is valid
// throughput: one access per cycle while s_axis_tready is high; registers update at the input transaction edge
// output register plus skid stage hold results while the output stalls
// reset: asynchronous active low, register file and handshake state cleared
module ohci_1394_register_file_top #(
  parameter int unsigned TX_CONTEXTS = ohci_pkg::TxContextsDefault,
  parameter int unsigned RX_CONTEXTS = ohci_pkg::RxContextsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // op, reg_offset, write_data, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // read_data, irq, zero pad
);
  ohci_pkg::access_t acc;
  logic              fire;
  logic [31:0]       rdata;
  logic              irq;
  logic              out_v_q, sk_v_q;
  logic [32:0]       out_q, sk_q;

  assign acc.op   = s_axis_tdata[0];
  assign acc.addr = s_axis_tdata[11:1] & ohci_pkg::AddrMask;
  assign acc.data = s_axis_tdata[43:12];

  // irq reflects state after the access, so sample it in the cycle after the access
  logic        pend_q;
  logic [31:0] prd_q;
  logic [32:0] res;
  assign res = {irq, prd_q};

  assign s_axis_tready = !sk_v_q && !(pend_q && out_v_q && !m_axis_tready);
  assign fire = s_axis_tvalid && s_axis_tready;

  ohci_regs #(.TX_CONTEXTS(TX_CONTEXTS), .RX_CONTEXTS(RX_CONTEXTS)) u_regs (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(fire), .acc_i(acc),
    .rdata_o(rdata), .irq_o(irq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      pend_q <= fire;
      if (fire) prd_q <= rdata;
      if (!out_v_q || m_axis_tready) begin
        if (sk_v_q) begin
          out_q  <= sk_q;
          out_v_q <= 1'b1;
          sk_v_q <= pend_q;
          if (pend_q) sk_q <= res;
        end else begin
          out_v_q <= pend_q;
          if (pend_q) out_q <= res;
        end
      end else if (pend_q) begin
        sk_v_q <= 1'b1;
        sk_q   <= res;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, out_q};
endmodule
